FILE: hdl/srsi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package srsi_pkg;

    localparam int ROWS        = 256;
    localparam int ROW_CAP     = 16;
    localparam int COLUMN_BITS = 16;

    localparam int ROW_BITS    = $clog2(ROWS);
    localparam int SLOT_BITS   = $clog2(ROW_CAP);
    localparam int LEN_BITS    = $clog2(ROW_CAP + 1);
    localparam int ADDR_BITS   = ROW_BITS + SLOT_BITS;
    localparam int CFG_BITS    = 9;
    localparam int TOTAL_BITS  = 13;
    localparam int STATUS_BITS = 2;
    localparam int POS_BITS    = 5;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_ADDED = 2'd0,
        ST_DUP   = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    typedef struct packed {
        logic [ROW_BITS-1:0]    row;
        logic [COLUMN_BITS-1:0] column;
        logic                   check_duplicate;
        logic                   last_candidate;
        logic                   in_range;
    } item_t;

endpackage

`default_nettype wire

FILE: hdl/srsi_front.sv
`timescale 1ns / 1ps
`default_nettype none

module srsi_front (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_wr_en,
    input  wire logic [srsi_pkg::CFG_BITS-1:0]      cfg_wr_data,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [srsi_pkg::ROW_BITS-1:0]      s_row,
    input  wire logic [srsi_pkg::COLUMN_BITS-1:0]   s_column,
    input  wire logic                               s_check_duplicate,
    input  wire logic                               s_last_candidate,
    input  wire logic                               q_full,
    output logic                                    q_push,
    output srsi_pkg::item_t                         q_item
);

    localparam logic [srsi_pkg::CFG_BITS-1:0] ROW_LIMIT = srsi_pkg::CFG_BITS'(srsi_pkg::ROWS);

    logic [srsi_pkg::CFG_BITS-1:0] active_rows_reg;
    logic [srsi_pkg::CFG_BITS-1:0] limit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_rows_reg <= srsi_pkg::CFG_BITS'(256);
        end else if (cfg_wr_en) begin
            active_rows_reg <= cfg_wr_data;
        end
    end

    assign limit   = (active_rows_reg < ROW_LIMIT) ? active_rows_reg : ROW_LIMIT;
    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    always_comb begin
        q_item.row             = s_row;
        q_item.column          = s_column;
        q_item.check_duplicate = s_check_duplicate;
        q_item.last_candidate  = s_last_candidate;
        q_item.in_range        = ({1'b0, s_row} < limit);
    end

endmodule

`default_nettype wire

FILE: hdl/srsi_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module srsi_queue (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  wire srsi_pkg::item_t push_item,
    output logic                 full,
    input  wire logic            pop,
    output logic                 not_empty,
    output srsi_pkg::item_t      pop_item
);

    srsi_pkg::item_t slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_item  = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            unique case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: hdl/srsi_back.sv
`timescale 1ns / 1ps
`default_nettype none

module srsi_back (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               q_not_empty,
    input  wire srsi_pkg::item_t                    q_item,
    output logic                                    q_pop,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic [srsi_pkg::STATUS_BITS-1:0]        m_status,
    output logic [srsi_pkg::POS_BITS-1:0]           m_position,
    output logic [srsi_pkg::POS_BITS-1:0]           m_row_length,
    output logic [srsi_pkg::TOTAL_BITS-1:0]         m_total_entries,
    output logic                                    m_batch_done
);

    localparam logic [srsi_pkg::LEN_BITS-1:0] CAP = srsi_pkg::LEN_BITS'(srsi_pkg::ROW_CAP);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_LEN,
        S_SCAN,
        S_APPEND,
        S_DONE
    } state_t;

    state_t                              state_reg;
    srsi_pkg::item_t                     item_reg;
    logic [srsi_pkg::LEN_BITS-1:0]       len_reg;
    logic [srsi_pkg::SLOT_BITS-1:0]      scan_idx_reg;
    logic [srsi_pkg::SLOT_BITS-1:0]      cmp_idx_reg;
    logic                                cmp_valid_reg;
    srsi_pkg::status_t                   res_status_reg;
    logic [srsi_pkg::LEN_BITS-1:0]       res_pos_reg;
    logic [srsi_pkg::LEN_BITS-1:0]       res_len_reg;
    logic [srsi_pkg::TOTAL_BITS-1:0]     total_reg;
    logic                                m_valid_reg;
    logic [srsi_pkg::STATUS_BITS-1:0]    m_status_reg;
    logic [srsi_pkg::POS_BITS-1:0]       m_position_reg;
    logic [srsi_pkg::POS_BITS-1:0]       m_row_length_reg;
    logic [srsi_pkg::TOTAL_BITS-1:0]     m_total_reg;
    logic                                m_batch_reg;

    logic [srsi_pkg::COLUMN_BITS-1:0]    column_store_mem [2**srsi_pkg::ADDR_BITS];
    logic [srsi_pkg::LEN_BITS-1:0]       row_length_mem [srsi_pkg::ROWS];
    logic                                row_valid_reg [srsi_pkg::ROWS];
    logic [srsi_pkg::COLUMN_BITS-1:0]    col_rd_reg;
    logic [srsi_pkg::LEN_BITS-1:0]       len_rd_reg;
    logic                                vbit_rd_reg;

    logic                                append_we;
    logic [srsi_pkg::ADDR_BITS-1:0]      col_waddr;
    logic [srsi_pkg::ADDR_BITS-1:0]      col_raddr;
    logic [srsi_pkg::LEN_BITS-1:0]       len_now;
    logic [srsi_pkg::LEN_BITS-1:0]       len_last;
    logic [srsi_pkg::LEN_BITS-1:0]       len_inc;

    assign append_we = (state_reg == S_APPEND) && (len_reg != CAP);
    assign col_waddr = {item_reg.row, len_reg[srsi_pkg::SLOT_BITS-1:0]};
    assign col_raddr = {item_reg.row, scan_idx_reg};
    assign len_now   = vbit_rd_reg ? len_rd_reg : '0;
    assign len_last  = len_reg - srsi_pkg::LEN_BITS'(1);
    assign len_inc   = len_reg + srsi_pkg::LEN_BITS'(1);
    assign q_pop     = (state_reg == S_IDLE);

    always_ff @(posedge aclk) begin
        if (append_we) begin
            column_store_mem[col_waddr] <= item_reg.column;
        end
        col_rd_reg <= column_store_mem[col_raddr];
    end

    always_ff @(posedge aclk) begin
        if (append_we) begin
            row_length_mem[item_reg.row] <= len_inc;
        end
        len_rd_reg <= row_length_mem[item_reg.row];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < srsi_pkg::ROWS; i++) begin
                row_valid_reg[srsi_pkg::ROW_BITS'(i)] <= 1'b0;
            end
        end else if (append_we) begin
            row_valid_reg[item_reg.row] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        vbit_rd_reg <= row_valid_reg[item_reg.row];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            total_reg     <= '0;
            m_valid_reg   <= 1'b0;
            cmp_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && (state_reg != S_DONE)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (q_not_empty) begin
                        item_reg <= q_item;
                        if (q_item.in_range) begin
                            state_reg <= S_LOOK;
                        end else begin
                            res_status_reg <= srsi_pkg::ST_RANGE;
                            res_pos_reg    <= '0;
                            res_len_reg    <= '0;
                            state_reg      <= S_DONE;
                        end
                    end
                end
                S_LOOK: begin
                    state_reg <= S_LEN;
                end
                S_LEN: begin
                    len_reg       <= len_now;
                    scan_idx_reg  <= '0;
                    cmp_valid_reg <= 1'b0;
                    if (item_reg.check_duplicate && (len_now != '0)) begin
                        state_reg <= S_SCAN;
                    end else begin
                        state_reg <= S_APPEND;
                    end
                end
                S_SCAN: begin
                    if (cmp_valid_reg && (col_rd_reg == item_reg.column)) begin
                        res_status_reg <= srsi_pkg::ST_DUP;
                        res_pos_reg    <= {1'b0, cmp_idx_reg};
                        res_len_reg    <= len_reg;
                        state_reg      <= S_DONE;
                    end else if (cmp_valid_reg &&
                                 (cmp_idx_reg == len_last[srsi_pkg::SLOT_BITS-1:0])) begin
                        state_reg <= S_APPEND;
                    end else begin
                        cmp_idx_reg   <= scan_idx_reg;
                        cmp_valid_reg <= 1'b1;
                        if (scan_idx_reg != len_last[srsi_pkg::SLOT_BITS-1:0]) begin
                            scan_idx_reg <= scan_idx_reg + srsi_pkg::SLOT_BITS'(1);
                        end
                    end
                end
                S_APPEND: begin
                    if (len_reg == CAP) begin
                        res_status_reg <= srsi_pkg::ST_FULL;
                        res_pos_reg    <= CAP;
                        res_len_reg    <= CAP;
                    end else begin
                        res_status_reg <= srsi_pkg::ST_ADDED;
                        res_pos_reg    <= len_reg;
                        res_len_reg    <= len_inc;
                        total_reg      <= total_reg + srsi_pkg::TOTAL_BITS'(1);
                    end
                    state_reg <= S_DONE;
                end
                S_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg      <= 1'b1;
                        m_status_reg     <= res_status_reg;
                        m_position_reg   <= srsi_pkg::POS_BITS'(res_pos_reg);
                        m_row_length_reg <= srsi_pkg::POS_BITS'(res_len_reg);
                        m_total_reg      <= total_reg;
                        m_batch_reg      <= item_reg.last_candidate;
                        state_reg        <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_position      = m_position_reg;
    assign m_row_length    = m_row_length_reg;
    assign m_total_entries = m_total_reg;
    assign m_batch_done    = m_batch_reg;

endmodule

`default_nettype wire

FILE: hdl/sparse_row_set_insert.sv
// Sparse row set insert: keeps up to 16 column indices for each of 256 rows.
// Input words arrive on the s_ channel (valid/ready) and carry a row, a column,
// a duplicate-check flag and a batch marker; each word yields exactly one
// result word on the m_ channel (valid/ready) with status, slot, row length
// and the running total of stored entries.
// The front accepts words into a two-entry queue and tags rows that are out
// of range; the back reads the row length, scans the row one stored entry per
// cycle when the check is requested, and appends the column unless a match
// was found or the row is full. The column memory read port sets the scan rate.
// The input keeps accepting while the queue has room, even while a finished
// result waits in the output register; a stalled receiver holds the back in
// its final step until the result register is free.
// Reset empties the queue, clears all row lengths and the total at once, and
// sets active_rows to 256. The cfg_wr_en/cfg_wr_data port writes active_rows
// and the user must use it only while idle: the block does not enforce that.
`timescale 1ns / 1ps
`default_nettype none

module sparse_row_set_insert (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_wr_en,
    input  wire logic [srsi_pkg::CFG_BITS-1:0]      cfg_wr_data,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [srsi_pkg::ROW_BITS-1:0]      s_row,
    input  wire logic [srsi_pkg::COLUMN_BITS-1:0]   s_column,
    input  wire logic                               s_check_duplicate,
    input  wire logic                               s_last_candidate,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic [srsi_pkg::STATUS_BITS-1:0]        m_status,
    output logic [srsi_pkg::POS_BITS-1:0]           m_position,
    output logic [srsi_pkg::POS_BITS-1:0]           m_row_length,
    output logic [srsi_pkg::TOTAL_BITS-1:0]         m_total_entries,
    output logic                                    m_batch_done
);

    logic            q_full;
    logic            q_push;
    logic            q_pop;
    logic            q_not_empty;
    srsi_pkg::item_t push_item;
    srsi_pkg::item_t pop_item;

    srsi_front u_front (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_row             (s_row),
        .s_column          (s_column),
        .s_check_duplicate (s_check_duplicate),
        .s_last_candidate  (s_last_candidate),
        .q_full            (q_full),
        .q_push            (q_push),
        .q_item            (push_item)
    );

    srsi_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_item  (pop_item)
    );

    srsi_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_not_empty     (q_not_empty),
        .q_item          (pop_item),
        .q_pop           (q_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_position      (m_position),
        .m_row_length    (m_row_length),
        .m_total_entries (m_total_entries),
        .m_batch_done    (m_batch_done)
    );

endmodule

`default_nettype wire

FILE: test/sparse_row_set_insert_tb.sv
`timescale 1ns / 1ps

module sparse_row_set_insert_tb;

    localparam int STALL_LIMIT = 2000;

    typedef struct packed {
        srsi_pkg::status_t                status;
        logic [srsi_pkg::POS_BITS-1:0]    position;
        logic [srsi_pkg::POS_BITS-1:0]    row_length;
        logic [srsi_pkg::TOTAL_BITS-1:0]  total;
        logic                             batch_done;
    } result_t;

    typedef struct packed {
        logic                             setup;
        logic [srsi_pkg::CFG_BITS-1:0]    cfg_value;
        logic [srsi_pkg::ROW_BITS-1:0]    row;
        logic [srsi_pkg::COLUMN_BITS-1:0] column;
        logic                             check;
        logic                             last;
        logic [4:0]                       reps;
        logic                             typed;
        result_t                          want;
    } plan_step_t;

    logic                             aclk;
    logic                             aresetn = 1'b0;
    logic                             cfg_wr_en = 1'b0;
    logic [srsi_pkg::CFG_BITS-1:0]    cfg_wr_data = '0;
    logic                             s_valid = 1'b0;
    logic                             s_ready;
    logic [srsi_pkg::ROW_BITS-1:0]    s_row = '0;
    logic [srsi_pkg::COLUMN_BITS-1:0] s_column = '0;
    logic                             s_check_duplicate = 1'b0;
    logic                             s_last_candidate = 1'b0;
    logic                             m_valid;
    logic                             m_ready = 1'b0;
    logic [srsi_pkg::STATUS_BITS-1:0] m_status;
    logic [srsi_pkg::POS_BITS-1:0]    m_position;
    logic [srsi_pkg::POS_BITS-1:0]    m_row_length;
    logic [srsi_pkg::TOTAL_BITS-1:0]  m_total_entries;
    logic                             m_batch_done;

    logic [srsi_pkg::COLUMN_BITS-1:0] col_store [srsi_pkg::ROWS][srsi_pkg::ROW_CAP];
    int unsigned                      row_len [srsi_pkg::ROWS];
    logic [srsi_pkg::TOTAL_BITS-1:0]  entry_total = '0;
    logic [srsi_pkg::CFG_BITS-1:0]    active_rows_now = 9'd256;

    result_t    pending [$];
    plan_step_t plan [$];
    int         err_count = 0;
    int         stall_left = 0;
    int         idle_cycles = 0;
    logic       valid_up = 1'b0;
    logic       quiet = 1'b0;

    sparse_row_set_insert dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_row             (s_row),
        .s_column          (s_column),
        .s_check_duplicate (s_check_duplicate),
        .s_last_candidate  (s_last_candidate),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_position        (m_position),
        .m_row_length      (m_row_length),
        .m_total_entries   (m_total_entries),
        .m_batch_done      (m_batch_done)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic result_t predict_insert(input logic [srsi_pkg::ROW_BITS-1:0] r,
                                               input logic [srsi_pkg::COLUMN_BITS-1:0] c,
                                               input logic chk, input logic last);
        result_t     res;
        int unsigned lim;
        int unsigned n;
        int unsigned slot;
        logic        found;
        int          i;
        lim = (active_rows_now < srsi_pkg::ROWS) ? active_rows_now : srsi_pkg::ROWS;
        res.batch_done = last;
        if (r >= lim) begin
            res.status     = srsi_pkg::ST_RANGE;
            res.position   = '0;
            res.row_length = '0;
            res.total      = entry_total;
            return res;
        end
        n = row_len[r];
        found = 1'b0;
        slot = n;
        if (chk) begin
            for (i = 0; i < n; i++) begin
                if (!found && col_store[r][srsi_pkg::SLOT_BITS'(i)] == c) begin
                    found = 1'b1;
                    slot = i;
                end
            end
        end
        if (found) begin
            res.status     = srsi_pkg::ST_DUP;
            res.position   = slot[srsi_pkg::POS_BITS-1:0];
            res.row_length = n[srsi_pkg::POS_BITS-1:0];
        end else if (n >= srsi_pkg::ROW_CAP) begin
            res.status     = srsi_pkg::ST_FULL;
            res.position   = srsi_pkg::POS_BITS'(srsi_pkg::ROW_CAP);
            res.row_length = n[srsi_pkg::POS_BITS-1:0];
        end else begin
            col_store[r][srsi_pkg::SLOT_BITS'(n)] = c;
            row_len[r] = n + 1;
            entry_total = entry_total + 1'b1;
            res.status     = srsi_pkg::ST_ADDED;
            res.position   = n[srsi_pkg::POS_BITS-1:0];
            res.row_length = n[srsi_pkg::POS_BITS-1:0] + 1'b1;
        end
        res.total = entry_total;
        return res;
    endfunction

    function automatic int pause_len();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void plan_word(input logic [srsi_pkg::ROW_BITS-1:0] r,
                                      input logic [srsi_pkg::COLUMN_BITS-1:0] c,
                                      input logic chk, input logic last,
                                      input int reps);
        plan_step_t st;
        st = '0;
        st.row = r;
        st.column = c;
        st.check = chk;
        st.last = last;
        st.reps = reps[4:0];
        plan.insert(plan.size(), st);
    endfunction

    function automatic void plan_known(input logic [srsi_pkg::ROW_BITS-1:0] r,
                                       input logic [srsi_pkg::COLUMN_BITS-1:0] c,
                                       input logic chk, input logic last,
                                       input srsi_pkg::status_t st_code, input int pos,
                                       input int len, input int tot);
        plan_step_t st;
        st = '0;
        st.row = r;
        st.column = c;
        st.check = chk;
        st.last = last;
        st.reps = 5'd1;
        st.typed = 1'b1;
        st.want.status = st_code;
        st.want.position = pos[srsi_pkg::POS_BITS-1:0];
        st.want.row_length = len[srsi_pkg::POS_BITS-1:0];
        st.want.total = tot[srsi_pkg::TOTAL_BITS-1:0];
        st.want.batch_done = last;
        plan.insert(plan.size(), st);
    endfunction

    function automatic void plan_setup(input logic [srsi_pkg::CFG_BITS-1:0] v);
        plan_step_t st;
        st = '0;
        st.setup = 1'b1;
        st.cfg_value = v;
        plan.insert(plan.size(), st);
    endfunction

    task automatic flag_error(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        err_count++;
    endtask

    task automatic drop_valid();
        if (valid_up) begin
            s_valid <= 1'b0;
            valid_up = 1'b0;
        end
    endtask

    task automatic send_word(input logic [srsi_pkg::ROW_BITS-1:0] r,
                             input logic [srsi_pkg::COLUMN_BITS-1:0] c,
                             input logic chk, input logic last,
                             input logic typed, input result_t want);
        int      gap;
        result_t got;
        gap = pause_len();
        if (gap > 0) begin
            drop_valid();
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_row <= r;
        s_column <= c;
        s_check_duplicate <= chk;
        s_last_candidate <= last;
        valid_up = 1'b1;
        do @(posedge aclk); while (!s_ready);
        got = predict_insert(r, c, chk, last);
        pending.insert(pending.size(), typed ? want : got);
    endtask

    task automatic write_active_rows(input logic [srsi_pkg::CFG_BITS-1:0] v);
        drop_valid();
        while (pending.size() != 0) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        active_rows_now = v;
    endtask

    task automatic run_phase(input logic [srsi_pkg::CFG_BITS-1:0] cfg, input int count);
        logic [srsi_pkg::ROW_BITS-1:0]    hot [8];
        logic [srsi_pkg::ROW_BITS-1:0]    r;
        logic [srsi_pkg::COLUMN_BITS-1:0] c;
        int                               lim;
        int                               sent;
        int                               blen;
        int                               pick;
        logic                             broken;
        write_active_rows(cfg);
        lim = (cfg < srsi_pkg::ROWS) ? cfg : srsi_pkg::ROWS;
        foreach (hot[i]) begin
            if (lim > 0 && $urandom_range(0, 3) != 0)
                hot[i] = srsi_pkg::ROW_BITS'($urandom_range(0, lim - 1));
            else
                hot[i] = srsi_pkg::ROW_BITS'($urandom_range(0, srsi_pkg::ROWS - 1));
        end
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 49) == 0) quiet = ($urandom_range(0, 2) == 0);
            if ($urandom_range(0, 3) == 0) begin
                send_word(srsi_pkg::ROW_BITS'($urandom_range(0, srsi_pkg::ROWS - 1)),
                          srsi_pkg::COLUMN_BITS'($urandom), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), 1'b0, '0);
                sent++;
            end else begin
                if ($urandom_range(0, 9) < 7) r = hot[3'($urandom_range(0, 7))];
                else r = srsi_pkg::ROW_BITS'($urandom_range(0, srsi_pkg::ROWS - 1));
                blen = $urandom_range(1, 6);
                broken = ($urandom_range(0, 9) == 0);
                for (int k = 0; k < blen; k++) begin
                    pick = $urandom_range(0, 9);
                    if (pick < 5) c = srsi_pkg::COLUMN_BITS'($urandom_range(0, 11));
                    else if (pick == 5) c = '1;
                    else if (pick == 6) c = '0;
                    else c = srsi_pkg::COLUMN_BITS'($urandom);
                    send_word(r, c, $urandom_range(0, 9) != 0,
                              (k == blen - 1) && !broken, 1'b0, '0);
                    sent++;
                end
            end
        end
        quiet = 1'b0;
    endtask

    task automatic check_result();
        result_t got;
        result_t want;
        got = {m_status, m_position, m_row_length, m_total_entries, m_batch_done};
        if (pending.size() == 0) begin
            flag_error($sformatf("result word with none expected: status %0d pos %0d len %0d",
                                 m_status, m_position, m_row_length));
            return;
        end
        want = pending.pop_front();
        if (got !== want) begin
            flag_error($sformatf({"status %0d/%0d pos %0d/%0d len %0d/%0d ",
                                  "total %0d/%0d batch_done %0d/%0d (got/expected)"},
                                 got.status, want.status, got.position, want.position,
                                 got.row_length, want.row_length, got.total, want.total,
                                 got.batch_done, want.batch_done));
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) check_result();
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                stall_left = pause_len();
            end
        end
    end

    initial begin
        @(posedge aresetn);
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        foreach (row_len[i]) row_len[i] = 0;

        plan_known(8'd0, 16'h0000, 1'b1, 1'b0, srsi_pkg::ST_ADDED, 0, 1, 1);
        plan_known(8'd0, 16'h0000, 1'b1, 1'b1, srsi_pkg::ST_DUP, 0, 1, 1);
        plan_known(8'd0, 16'h0000, 1'b0, 1'b0, srsi_pkg::ST_ADDED, 1, 2, 2);
        plan_known(8'd255, 16'hFFFF, 1'b1, 1'b1, srsi_pkg::ST_ADDED, 0, 1, 3);
        plan_known(8'd255, 16'hFFFF, 1'b1, 1'b0, srsi_pkg::ST_DUP, 0, 1, 3);
        plan_word(8'd0, 16'h0100, 1'b1, 1'b0, 14);
        // A duplicate in a full row wins over the full status.
        plan_known(8'd0, 16'h0000, 1'b1, 1'b1, srsi_pkg::ST_DUP, 0, 16, 17);
        plan_known(8'd0, 16'h8000, 1'b1, 1'b0, srsi_pkg::ST_FULL, 16, 16, 17);
        plan_known(8'd0, 16'h0000, 1'b0, 1'b1, srsi_pkg::ST_FULL, 16, 16, 17);
        plan_setup(9'd0);
        plan_known(8'd0, 16'h5555, 1'b1, 1'b0, srsi_pkg::ST_RANGE, 0, 0, 17);
        plan_setup(9'd1);
        plan_known(8'd1, 16'hAAAA, 1'b1, 1'b1, srsi_pkg::ST_RANGE, 0, 0, 17);
        plan_word(8'd0, 16'h010D, 1'b1, 1'b0, 1);
        plan_setup(9'd511);

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        write_active_rows(9'd256);

        foreach (plan[i]) begin
            if (plan[i].setup) begin
                write_active_rows(plan[i].cfg_value);
            end else begin
                for (int k = 0; k < plan[i].reps; k++) begin
                    send_word(plan[i].row, plan[i].column + srsi_pkg::COLUMN_BITS'(k),
                              plan[i].check, plan[i].last, plan[i].typed, plan[i].want);
                end
            end
        end

        run_phase(9'd511, 340);
        run_phase(srsi_pkg::CFG_BITS'($urandom_range(2, 254)), 250);
        run_phase(9'd0, 60);
        run_phase(9'd255, 250);
        run_phase(9'd1, 80);
        run_phase(srsi_pkg::CFG_BITS'($urandom_range(0, 511)), 200);
        run_phase(9'd256, 245);

        drop_valid();
        while (pending.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hdl/srsi_pkg.sv
hdl/srsi_front.sv
hdl/srsi_queue.sv
hdl/srsi_back.sv
hdl/sparse_row_set_insert.sv
test/sparse_row_set_insert_tb.sv
